@@ design/u8bd_pkg.sv @@
// shared types and constants for the utf-8 gpt-2 byte decoder
package u8bd_pkg;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_CONT     = 3'd1,
		ERR_OVERLONG = 3'd2,
		ERR_RANGE    = 3'd3,
		ERR_LEAD     = 3'd4,
		ERR_TRUNC    = 3'd5,
		ERR_UNMAPPED = 3'd6
	} err_t;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] CP_MIN_2B    = 21'h00080;
	localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h00800;
	localparam logic [CP_W-1:0] CP_MIN_4B    = 21'h10000;
	localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
	localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
	localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

	localparam logic [CP_W-1:0] MAP_A_LO     = 21'd33;
	localparam logic [CP_W-1:0] MAP_A_HI     = 21'd126;
	localparam logic [CP_W-1:0] MAP_B_LO     = 21'd161;
	localparam logic [CP_W-1:0] MAP_B_HI     = 21'd172;
	localparam logic [CP_W-1:0] MAP_C_LO     = 21'd174;
	localparam logic [CP_W-1:0] MAP_C_HI     = 21'd255;
	localparam logic [CP_W-1:0] MAP_SHIFT_LO = 21'd256;
	localparam logic [CP_W-1:0] MAP_SHIFT_HI = 21'd323;

	localparam logic [6:0] SHIFT_LOW_END = 7'd33;
	localparam logic [6:0] SHIFT_MID_END = 7'd67;
	localparam logic [7:0] SHIFT_MID_ADD = 8'd94;
	localparam logic [7:0] SHIFT_LAST    = 8'd173;

	typedef struct packed {
		logic [1:0]      bytes_left;
		logic [2:0]      seq_len;
		logic [CP_W-1:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic       has_result;
		logic [7:0] out_byte;
		err_t       error_code;
	} dec_result_t;

endpackage

@@ design/u8bd_in_if.sv @@
// input channel: one utf-8 text byte per item
interface u8bd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       token_end;

	modport source(output valid, output text_byte, output token_end, input ready);
	modport sink(input valid, input text_byte, input token_end, output ready);
endinterface

@@ design/u8bd_out_if.sv @@
// output channel: one decoded byte or error per item
interface u8bd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] error_code;

	modport source(output valid, output out_byte, output error_code, input ready);
	modport sink(input valid, input out_byte, input error_code, output ready);
endinterface

@@ design/u8bd_unmap.sv @@
// inverse gpt-2 byte map from code point to original byte
module u8bd_unmap (
	input  logic [u8bd_pkg::CP_W-1:0] code_point,
	output logic                      mapped,
	output logic [7:0]                orig_byte
);

	logic       self_map;
	logic       shift_map;
	logic [6:0] k;

	always_comb begin
		self_map = (code_point >= u8bd_pkg::MAP_A_LO && code_point <= u8bd_pkg::MAP_A_HI) ||
			(code_point >= u8bd_pkg::MAP_B_LO && code_point <= u8bd_pkg::MAP_B_HI) ||
			(code_point >= u8bd_pkg::MAP_C_LO && code_point <= u8bd_pkg::MAP_C_HI);
		shift_map = code_point >= u8bd_pkg::MAP_SHIFT_LO &&
			code_point <= u8bd_pkg::MAP_SHIFT_HI;
		// offset from 256 fits in the low seven bits over the shifted range
		k = code_point[6:0];
		mapped = self_map || shift_map;
		if (self_map) begin
			orig_byte = code_point[7:0];
		end else if (!shift_map) begin
			orig_byte = 8'd0;
		end else if (k < u8bd_pkg::SHIFT_LOW_END) begin
			orig_byte = {1'b0, k};
		end else if (k < u8bd_pkg::SHIFT_MID_END) begin
			orig_byte = {1'b0, k} + u8bd_pkg::SHIFT_MID_ADD;
		end else begin
			orig_byte = u8bd_pkg::SHIFT_LAST;
		end
	end

endmodule

@@ design/u8bd_decode.sv @@
// per-byte utf-8 decode step: next state and optional result
module u8bd_decode (
	input  u8bd_pkg::dec_state_t  cur,
	input  logic [7:0]            text_byte,
	input  logic                  token_end,
	output u8bd_pkg::dec_state_t  nxt,
	output u8bd_pkg::dec_result_t res
);

	logic [u8bd_pkg::CP_W-1:0] fin_cp;
	logic [2:0]                fin_len;
	logic                      fin_go;
	logic                      mapped;
	logic [7:0]                orig_byte;
	logic [u8bd_pkg::CP_W-1:0] shifted;

	u8bd_unmap u_unmap (
		.code_point(fin_cp),
		.mapped    (mapped),
		.orig_byte (orig_byte)
	);

	always_comb begin
		nxt     = '0;
		res     = '0;
		fin_go  = 1'b0;
		fin_len = 3'd1;
		fin_cp  = {13'd0, text_byte};
		shifted = {cur.partial[u8bd_pkg::CP_W-7:0], text_byte[5:0]};
		res.error_code = u8bd_pkg::ERR_OK;

		if (cur.bytes_left == 2'd0) begin
			if (!text_byte[7]) begin
				fin_go = 1'b1;
			end else if (text_byte[7:5] == 3'b110) begin
				nxt.partial    = {16'd0, text_byte[4:0]};
				nxt.seq_len    = 3'd2;
				nxt.bytes_left = 2'd1;
			end else if (text_byte[7:4] == 4'b1110) begin
				nxt.partial    = {17'd0, text_byte[3:0]};
				nxt.seq_len    = 3'd3;
				nxt.bytes_left = 2'd2;
			end else if (text_byte[7:3] == 5'b11110) begin
				nxt.partial    = {18'd0, text_byte[2:0]};
				nxt.seq_len    = 3'd4;
				nxt.bytes_left = 2'd3;
			end else begin
				res.has_result = 1'b1;
				res.error_code = u8bd_pkg::ERR_LEAD;
			end
			if (text_byte[7] && nxt.bytes_left != 2'd0 && token_end) begin
				nxt            = '0;
				res.has_result = 1'b1;
				res.error_code = u8bd_pkg::ERR_TRUNC;
			end
		end else if (text_byte[7:6] != 2'b10) begin
			res.has_result = 1'b1;
			res.error_code = u8bd_pkg::ERR_CONT;
		end else if (cur.bytes_left == 2'd1) begin
			fin_go  = 1'b1;
			fin_cp  = shifted;
			fin_len = cur.seq_len;
		end else if (token_end) begin
			res.has_result = 1'b1;
			res.error_code = u8bd_pkg::ERR_TRUNC;
		end else begin
			nxt.partial    = shifted;
			nxt.seq_len    = cur.seq_len;
			nxt.bytes_left = cur.bytes_left - 2'd1;
		end

		if (fin_go) begin
			res.has_result = 1'b1;
			if (fin_len == 3'd2 && fin_cp < u8bd_pkg::CP_MIN_2B) begin
				res.error_code = u8bd_pkg::ERR_OVERLONG;
			end else if (fin_len == 3'd3 && fin_cp < u8bd_pkg::CP_MIN_3B) begin
				res.error_code = u8bd_pkg::ERR_OVERLONG;
			end else if (fin_len == 3'd3 && fin_cp >= u8bd_pkg::CP_SURR_LO &&
					fin_cp <= u8bd_pkg::CP_SURR_HI) begin
				res.error_code = u8bd_pkg::ERR_RANGE;
			end else if (fin_len == 3'd4 && fin_cp < u8bd_pkg::CP_MIN_4B) begin
				res.error_code = u8bd_pkg::ERR_OVERLONG;
			end else if (fin_len == 3'd4 && fin_cp > u8bd_pkg::CP_MAX) begin
				res.error_code = u8bd_pkg::ERR_RANGE;
			end else if (!mapped) begin
				res.error_code = u8bd_pkg::ERR_UNMAPPED;
			end else begin
				res.out_byte = orig_byte;
			end
		end
	end

endmodule

@@ design/utf8_gpt2_byte_decoder.sv @@
// top level: utf-8 to gpt-2 original byte decoder
// an accepted byte is registered in the input stage, decoded combinationally and its result registered for the output
// throughput: one item per cycle while the result channel is not stalled, set by the single decode step per byte
// a byte that completes no code point gives no result but still passes through the input stage
// reset: asynchronous, clears the input and result valid flags and the decoder state
module utf8_gpt2_byte_decoder (
	input  logic         clk,
	input  logic         arst_n,
	u8bd_in_if.sink      text_ch,
	u8bd_out_if.source   result_ch
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  end_s1;
	u8bd_pkg::dec_state_t  state_q;
	u8bd_pkg::dec_state_t  state_nxt;
	u8bd_pkg::dec_result_t res;
	logic                  res_valid_q;
	logic [7:0]            out_byte_q;
	logic [2:0]            error_code_q;
	logic                  adv;

	u8bd_decode u_decode (
		.cur      (state_q),
		.text_byte(byte_s1),
		.token_end(end_s1),
		.nxt      (state_nxt),
		.res      (res)
	);

	assign adv                  = !res_valid_q || result_ch.ready;
	assign text_ch.ready        = !valid_s1 || adv;
	assign result_ch.valid      = res_valid_q;
	assign result_ch.out_byte   = out_byte_q;
	assign result_ch.error_code = error_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= valid_s1 && res.has_result;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_ch.valid && text_ch.ready) begin
			byte_s1 <= text_ch.text_byte;
			end_s1  <= text_ch.token_end;
		end
		if (adv && valid_s1) begin
			out_byte_q   <= res.out_byte;
			error_code_q <= res.error_code;
		end
	end

endmodule
